// ===== rtl/i2cram_pkg.sv =====
package i2cram_pkg;

    // Bus sequencer phases, one-hot.
    typedef enum logic [15:0] {
        PH_IDLE = 16'b0000_0000_0000_0001,
        PH_ST0  = 16'b0000_0000_0000_0010,
        PH_ST1  = 16'b0000_0000_0000_0100,
        PH_ST2  = 16'b0000_0000_0000_1000,
        PH_RS   = 16'b0000_0000_0001_0000,
        PH_TXL  = 16'b0000_0000_0010_0000,
        PH_TXH  = 16'b0000_0000_0100_0000,
        PH_AKL  = 16'b0000_0000_1000_0000,
        PH_AKH  = 16'b0000_0001_0000_0000,
        PH_RXL  = 16'b0000_0010_0000_0000,
        PH_RXH  = 16'b0000_0100_0000_0000,
        PH_MAL  = 16'b0000_1000_0000_0000,
        PH_MAH  = 16'b0001_0000_0000_0000,
        PH_SP0  = 16'b0010_0000_0000_0000,
        PH_SP1  = 16'b0100_0000_0000_0000,
        PH_SP2  = 16'b1000_0000_0000_0000
    } t_phase;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Which byte of the transaction the sequencer is on.
    typedef enum logic [1:0] {
        STG_ADDR = 2'd0,
        STG_REG  = 2'd1,
        STG_DATA = 2'd2,
        STG_RSVD = 2'd3
    } t_stage;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam int         IN_DATA_W         = 32;
    localparam int         OUT_DATA_W        = 16;

endpackage

// ===== rtl/i2c_register_access_master.sv =====
// Channel   | Direction | Signals                         | Contents
// ----------+-----------+---------------------------------+---------------------------------
// s_axis    | in        | tvalid, tready, tdata, tuser    | one bus tick: SDA sample, command
// m_axis    | out       | tvalid, tready, tdata, tlast    | SCL/SDA drive, read byte, status
// cfg       | in        | i_cfg_wr_en, i_cfg_wr_data      | ACK timeout in ticks
//
// Every request is one bus tick; one request is accepted per clock cycle unless
// the input side stalls. A request passes through an input register, then the
// sequencer step and the result register, loaded once the result side has room.
// Reset is synchronous, active low, and returns the sequencer to the idle bus.
// A stalled result holds its register; the input side stalls only once both
// the input register and the result register are occupied.
module i2c_register_access_master_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [6:0] device_address, [14:7] register_address, [22:15] write_data,
    // [30:23] read_count, [31] sda_sample
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_axis_tuser,
    // Result requests
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive_enable, [10:3] read_byte,
    // [11] read_valid, [12] busy_res, [13] done_res, [14] ack_error, [15] zero
    output logic [15:0] o_m_axis_tdata,
    // last_byte
    output logic        o_m_axis_tlast,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    // Input register
    logic                                r_in_valid;
    logic [1:0]                          r_in_op;
    logic [i2cram_pkg::IN_DATA_W-1:0]    r_in_data;

    // Result register
    logic                                r_out_valid;
    logic [i2cram_pkg::OUT_DATA_W-1:0]   r_out_data;
    logic                                r_out_last;

    // Sequencer state
    i2cram_pkg::t_phase r_phase, n_phase, eff_phase;
    i2cram_pkg::t_stage r_stage, n_stage;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_left, n_left;
    logic [7:0] r_wait, n_wait;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_is_read, n_is_read;
    logic       r_abort, n_abort;
    logic [7:0] r_ack_timeout;

    // Step outputs
    logic       s_scl, s_sda, s_de, s_rv, s_last, s_busy, s_done, s_err;
    logic [7:0] s_rb;

    // Input fields
    logic [6:0] in_dev;
    logic [7:0] in_reg, in_wdata, in_count;
    logic       in_sda, in_cmd;

    logic step;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    assign in_dev   = r_in_data[6:0];
    assign in_reg   = r_in_data[14:7];
    assign in_wdata = r_in_data[22:15];
    assign in_count = r_in_data[30:23];
    assign in_sda   = r_in_data[31];
    assign in_cmd   = (r_in_op == i2cram_pkg::OP_WRITE) || (r_in_op == i2cram_pkg::OP_READ);

    // One bus tick of the sequencer.
    always_comb begin
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_left    = r_left;
        n_wait    = r_wait;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_is_read = r_is_read;
        n_abort   = r_abort;
        s_scl     = 1'b1;
        s_sda     = 1'b1;
        s_de      = 1'b1;
        s_rb      = 8'd0;
        s_rv      = 1'b0;
        s_last    = 1'b0;
        s_busy    = 1'b1;
        s_done    = 1'b0;
        s_err     = 1'b0;
        eff_phase = r_phase;

        // A command seen on an idle bus starts the transaction on this tick.
        if (r_phase == i2cram_pkg::PH_IDLE && in_cmd) begin
            n_dev     = in_dev;
            n_reg     = in_reg;
            n_data    = in_wdata;
            n_left    = (in_count == 8'd0) ? 8'd1 : in_count;
            n_is_read = (r_in_op == i2cram_pkg::OP_READ);
            n_stage   = i2cram_pkg::STG_ADDR;
            n_abort   = 1'b0;
            n_wait    = 8'd0;
            n_bit     = 3'd0;
            n_shift   = 8'd0;
            eff_phase = i2cram_pkg::PH_ST0;
        end

        case (eff_phase)
            i2cram_pkg::PH_IDLE: begin
                s_busy = 1'b0;
            end
            i2cram_pkg::PH_ST0: begin
                n_phase = i2cram_pkg::PH_ST1;
            end
            i2cram_pkg::PH_ST1: begin
                s_sda   = 1'b0;
                n_phase = i2cram_pkg::PH_ST2;
            end
            i2cram_pkg::PH_ST2: begin
                s_scl   = 1'b0;
                s_sda   = 1'b0;
                n_shift = {r_dev, (r_stage != i2cram_pkg::STG_ADDR)};
                n_bit   = 3'd0;
                n_phase = i2cram_pkg::PH_TXL;
            end
            i2cram_pkg::PH_RS: begin
                s_scl   = 1'b0;
                n_phase = i2cram_pkg::PH_ST0;
            end
            i2cram_pkg::PH_TXL: begin
                s_scl   = 1'b0;
                s_sda   = r_shift[7];
                n_phase = i2cram_pkg::PH_TXH;
            end
            i2cram_pkg::PH_TXH: begin
                s_sda   = r_shift[7];
                n_shift = {r_shift[6:0], 1'b0};
                if (r_bit == 3'd7) begin
                    n_bit   = 3'd0;
                    n_wait  = 8'd0;
                    n_phase = i2cram_pkg::PH_AKL;
                end else begin
                    n_bit   = r_bit + 3'd1;
                    n_phase = i2cram_pkg::PH_TXL;
                end
            end
            i2cram_pkg::PH_AKL: begin
                s_scl   = 1'b0;
                s_sda   = 1'b0;
                s_de    = 1'b0;
                n_phase = i2cram_pkg::PH_AKH;
            end
            i2cram_pkg::PH_AKH: begin
                s_sda = 1'b0;
                s_de  = 1'b0;
                if (in_sda) begin
                    // No ACK yet: keep waiting until the timeout, then stop.
                    if (r_wait >= r_ack_timeout) begin
                        n_abort = 1'b1;
                        n_phase = i2cram_pkg::PH_SP0;
                    end else begin
                        n_wait = r_wait + 8'd1;
                    end
                end else if (r_stage == i2cram_pkg::STG_ADDR) begin
                    n_stage = i2cram_pkg::STG_REG;
                    n_shift = r_reg;
                    n_bit   = 3'd0;
                    n_phase = i2cram_pkg::PH_TXL;
                end else if (r_stage == i2cram_pkg::STG_REG) begin
                    n_stage = i2cram_pkg::STG_DATA;
                    if (r_is_read) begin
                        n_phase = i2cram_pkg::PH_RS;
                    end else begin
                        n_shift = r_data;
                        n_bit   = 3'd0;
                        n_phase = i2cram_pkg::PH_TXL;
                    end
                end else if (r_is_read) begin
                    n_bit   = 3'd0;
                    n_shift = 8'd0;
                    n_phase = i2cram_pkg::PH_RXL;
                end else begin
                    n_phase = i2cram_pkg::PH_SP0;
                end
            end
            i2cram_pkg::PH_RXL: begin
                s_scl   = 1'b0;
                s_sda   = 1'b0;
                s_de    = 1'b0;
                n_phase = i2cram_pkg::PH_RXH;
            end
            i2cram_pkg::PH_RXH: begin
                s_sda   = 1'b0;
                s_de    = 1'b0;
                n_shift = {r_shift[6:0], in_sda};
                if (r_bit == 3'd7) begin
                    s_rv    = 1'b1;
                    s_rb    = n_shift;
                    s_last  = (r_left <= 8'd1);
                    n_bit   = 3'd0;
                    n_phase = i2cram_pkg::PH_MAL;
                end else begin
                    n_bit   = r_bit + 3'd1;
                    n_phase = i2cram_pkg::PH_RXL;
                end
            end
            i2cram_pkg::PH_MAL: begin
                // ACK every byte but the last, which gets a NACK.
                s_scl   = 1'b0;
                s_sda   = (r_left <= 8'd1);
                n_phase = i2cram_pkg::PH_MAH;
            end
            i2cram_pkg::PH_MAH: begin
                s_sda = (r_left <= 8'd1);
                if (r_left > 8'd1) begin
                    n_left  = r_left - 8'd1;
                    n_bit   = 3'd0;
                    n_shift = 8'd0;
                    n_phase = i2cram_pkg::PH_RXL;
                end else begin
                    n_phase = i2cram_pkg::PH_SP0;
                end
            end
            i2cram_pkg::PH_SP0: begin
                s_scl   = 1'b0;
                s_sda   = 1'b0;
                n_phase = i2cram_pkg::PH_SP1;
            end
            i2cram_pkg::PH_SP1: begin
                s_sda   = 1'b0;
                n_phase = i2cram_pkg::PH_SP2;
            end
            i2cram_pkg::PH_SP2: begin
                s_done  = 1'b1;
                s_busy  = 1'b0;
                s_err   = r_abort;
                n_abort = 1'b0;
                n_phase = i2cram_pkg::PH_IDLE;
            end
            default: begin
                s_busy  = 1'b0;
                n_phase = i2cram_pkg::PH_IDLE;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= i2cram_pkg::ACK_TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_ack_timeout <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata;
        end
    end

    // Sequencer state advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cram_pkg::PH_IDLE;
            r_stage   <= i2cram_pkg::STG_ADDR;
            r_bit     <= 3'd0;
            r_shift   <= 8'd0;
            r_left    <= 8'd0;
            r_wait    <= 8'd0;
            r_dev     <= 7'd0;
            r_reg     <= 8'd0;
            r_data    <= 8'd0;
            r_is_read <= 1'b0;
            r_abort   <= 1'b0;
        end else if (step) begin
            r_phase   <= n_phase;
            r_stage   <= n_stage;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_left    <= n_left;
            r_wait    <= n_wait;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_is_read <= n_is_read;
            r_abort   <= n_abort;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {1'b0, s_err, s_done, s_busy, s_rv, s_rb, s_de, s_sda, s_scl};
            r_out_last <= s_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // The tick after the final stop tick finds the bus idle.
    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_phase == i2cram_pkg::PH_SP2) |=> (r_phase == i2cram_pkg::PH_IDLE))
        else $error("sequencer did not return to idle after stop");

    // An ACK error is only reported together with the end of a transaction.
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[14]) |-> (r_out_data[13] && !r_out_data[12]))
        else $error("ack error without done");

    // An idle tick without a command reports not busy.
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_phase == i2cram_pkg::PH_IDLE && !in_cmd) |=> !r_out_data[12])
        else $error("busy reported on an idle tick");

    // The byte stage never reaches the unused code.
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage != i2cram_pkg::STG_RSVD)
        else $error("byte stage out of range");

endmodule

// ===== tb/sv/i2c_register_access_master_core_tb.sv =====
`timescale 1ns / 100ps

module i2c_register_access_master_core_tb;

    // Levels and status the block reports for one bus tick, last_byte on top,
    // then the tdata fields from bit 14 down to bit 0.
    typedef struct packed {
        logic       last_byte;
        logic       ack_error;
        logic       done_res;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       sda_drive_enable;
        logic       sda_level;
        logic       scl_level;
    } t_bus_levels;

    // Tracks the bus sequencer one tick at a time and holds the levels it must
    // produce, in request order.
    class bus_tick_scoreboard;
        i2cram_pkg::t_phase seq_phase;
        i2cram_pkg::t_stage byte_stage;
        logic [2:0]  bit_cnt;
        logic [7:0]  shift_reg;
        logic [7:0]  bytes_rem;
        logic [7:0]  ack_wait;
        logic [7:0]  ack_timeout;
        logic [6:0]  addr_held;
        logic [7:0]  reg_held;
        logic [7:0]  data_held;
        logic        read_txn;
        logic        abort_pending;
        t_bus_levels expected_levels[$];
        int          errors;
        int          ticks_checked;
        int          writes_started;
        int          reads_started;
        int          transfers_done;
        int          transfers_aborted;
        int          bytes_read;

        function new();
            seq_phase     = i2cram_pkg::PH_IDLE;
            byte_stage    = i2cram_pkg::STG_ADDR;
            bit_cnt       = '0;
            shift_reg     = '0;
            bytes_rem     = '0;
            ack_wait      = '0;
            ack_timeout   = i2cram_pkg::ACK_TIMEOUT_RESET;
            addr_held     = '0;
            reg_held      = '0;
            data_held     = '0;
            read_txn      = 1'b0;
            abort_pending = 1'b0;
            errors        = 0;
            ticks_checked = 0;
            writes_started    = 0;
            reads_started     = 0;
            transfers_done    = 0;
            transfers_aborted = 0;
            bytes_read        = 0;
        endfunction

        function void load_byte(logic [7:0] value);
            shift_reg = value;
            bit_cnt   = '0;
            seq_phase = i2cram_pkg::PH_TXL;
        endfunction

        // Advance the sequencer by one accepted tick and queue the levels it drives.
        function void note_tick(i2cram_pkg::t_op op, logic [31:0] data);
            t_bus_levels lv;
            logic        sda_in;
            sda_in = data[31];
            lv = '0;
            lv.scl_level        = 1'b1;
            lv.sda_level        = 1'b1;
            lv.sda_drive_enable = 1'b1;
            lv.busy_res         = 1'b1;

            // A command only starts on an idle bus; it drives the first START tick now.
            if (seq_phase == i2cram_pkg::PH_IDLE &&
                (op == i2cram_pkg::OP_WRITE || op == i2cram_pkg::OP_READ)) begin
                addr_held     = data[6:0];
                reg_held      = data[14:7];
                data_held     = data[22:15];
                bytes_rem     = (data[30:23] == 8'd0) ? 8'd1 : data[30:23];
                read_txn      = (op == i2cram_pkg::OP_READ);
                byte_stage    = i2cram_pkg::STG_ADDR;
                abort_pending = 1'b0;
                ack_wait      = '0;
                bit_cnt       = '0;
                shift_reg     = '0;
                seq_phase     = i2cram_pkg::PH_ST0;
                if (read_txn) reads_started++;
                else writes_started++;
            end

            case (seq_phase)
                i2cram_pkg::PH_ST0: begin
                    seq_phase = i2cram_pkg::PH_ST1;
                end
                i2cram_pkg::PH_ST1: begin
                    lv.sda_level = 1'b0;
                    seq_phase = i2cram_pkg::PH_ST2;
                end
                i2cram_pkg::PH_ST2: begin
                    lv.scl_level = 1'b0;
                    lv.sda_level = 1'b0;
                    load_byte({addr_held, byte_stage != i2cram_pkg::STG_ADDR});
                end
                i2cram_pkg::PH_RS: begin
                    lv.scl_level = 1'b0;
                    seq_phase = i2cram_pkg::PH_ST0;
                end
                i2cram_pkg::PH_TXL, i2cram_pkg::PH_TXH: begin
                    lv.scl_level = (seq_phase == i2cram_pkg::PH_TXH);
                    lv.sda_level = shift_reg[7];
                    if (seq_phase == i2cram_pkg::PH_TXL) begin
                        seq_phase = i2cram_pkg::PH_TXH;
                    end else begin
                        shift_reg = shift_reg << 1;
                        if (bit_cnt == 3'd7) begin
                            bit_cnt   = '0;
                            ack_wait  = '0;
                            seq_phase = i2cram_pkg::PH_AKL;
                        end else begin
                            bit_cnt++;
                            seq_phase = i2cram_pkg::PH_TXL;
                        end
                    end
                end
                i2cram_pkg::PH_AKL: begin
                    lv.scl_level = 1'b0;
                    lv.sda_level = 1'b0;
                    lv.sda_drive_enable = 1'b0;
                    seq_phase = i2cram_pkg::PH_AKH;
                end
                i2cram_pkg::PH_AKH: begin
                    lv.sda_level = 1'b0;
                    lv.sda_drive_enable = 1'b0;
                    // A high sample is a late ACK until the wait count runs out.
                    if (sda_in) begin
                        if (ack_wait >= ack_timeout) begin
                            abort_pending = 1'b1;
                            seq_phase = i2cram_pkg::PH_SP0;
                        end else begin
                            ack_wait++;
                        end
                    end else if (byte_stage == i2cram_pkg::STG_ADDR) begin
                        byte_stage = i2cram_pkg::STG_REG;
                        load_byte(reg_held);
                    end else if (byte_stage == i2cram_pkg::STG_REG) begin
                        byte_stage = i2cram_pkg::STG_DATA;
                        if (read_txn) seq_phase = i2cram_pkg::PH_RS;
                        else load_byte(data_held);
                    end else if (read_txn) begin
                        bit_cnt   = '0;
                        shift_reg = '0;
                        seq_phase = i2cram_pkg::PH_RXL;
                    end else begin
                        seq_phase = i2cram_pkg::PH_SP0;
                    end
                end
                i2cram_pkg::PH_RXL: begin
                    lv.scl_level = 1'b0;
                    lv.sda_level = 1'b0;
                    lv.sda_drive_enable = 1'b0;
                    seq_phase = i2cram_pkg::PH_RXH;
                end
                i2cram_pkg::PH_RXH: begin
                    lv.sda_level = 1'b0;
                    lv.sda_drive_enable = 1'b0;
                    shift_reg = {shift_reg[6:0], sda_in};
                    if (bit_cnt == 3'd7) begin
                        lv.read_valid = 1'b1;
                        lv.read_byte  = shift_reg;
                        lv.last_byte  = (bytes_rem <= 8'd1);
                        bit_cnt   = '0;
                        seq_phase = i2cram_pkg::PH_MAL;
                        bytes_read++;
                    end else begin
                        bit_cnt++;
                        seq_phase = i2cram_pkg::PH_RXL;
                    end
                end
                i2cram_pkg::PH_MAL, i2cram_pkg::PH_MAH: begin
                    // Master ACK on every byte but the last, NACK on the last.
                    lv.scl_level = (seq_phase == i2cram_pkg::PH_MAH);
                    lv.sda_level = (bytes_rem <= 8'd1);
                    if (seq_phase == i2cram_pkg::PH_MAL) begin
                        seq_phase = i2cram_pkg::PH_MAH;
                    end else if (bytes_rem > 8'd1) begin
                        bytes_rem--;
                        bit_cnt   = '0;
                        shift_reg = '0;
                        seq_phase = i2cram_pkg::PH_RXL;
                    end else begin
                        seq_phase = i2cram_pkg::PH_SP0;
                    end
                end
                i2cram_pkg::PH_SP0: begin
                    lv.scl_level = 1'b0;
                    lv.sda_level = 1'b0;
                    seq_phase = i2cram_pkg::PH_SP1;
                end
                i2cram_pkg::PH_SP1: begin
                    lv.sda_level = 1'b0;
                    seq_phase = i2cram_pkg::PH_SP2;
                end
                i2cram_pkg::PH_SP2: begin
                    lv.done_res  = 1'b1;
                    lv.busy_res  = 1'b0;
                    lv.ack_error = abort_pending;
                    abort_pending = 1'b0;
                    seq_phase = i2cram_pkg::PH_IDLE;
                    transfers_done++;
                    if (lv.ack_error) transfers_aborted++;
                end
                default: begin
                    seq_phase = i2cram_pkg::PH_IDLE;
                    lv.busy_res = 1'b0;
                end
            endcase
            expected_levels.push_back(lv);
        endfunction

        task report(string what);
            errors++;
            $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report($sformatf("tick %0d %s is 0x%0h, expected 0x%0h",
                                 ticks_checked, name, got, want));
        endtask

        // Compare one accepted result with the oldest pending tick.
        task check_levels(logic [15:0] tdata, logic tlast);
            t_bus_levels got;
            t_bus_levels want;
            ticks_checked++;
            if (expected_levels.size() == 0) begin
                report($sformatf("result 0x%04h arrived with no tick pending", tdata));
                return;
            end
            want = expected_levels.pop_front();
            got  = {tlast, tdata[14:0]};
            check_field("scl_level", got.scl_level, want.scl_level);
            check_field("sda_level", got.sda_level, want.sda_level);
            check_field("sda_drive_enable", got.sda_drive_enable, want.sda_drive_enable);
            check_field("read_byte", got.read_byte, want.read_byte);
            check_field("read_valid", got.read_valid, want.read_valid);
            check_field("busy_res", got.busy_res, want.busy_res);
            check_field("done_res", got.done_res, want.done_res);
            check_field("ack_error", got.ack_error, want.ack_error);
            check_field("last_byte", got.last_byte, want.last_byte);
            check_field("spare bit 15", tdata[15], 0);
        endtask
    endclass

    localparam int ITEM_TARGET = 800;
    localparam int DRAIN_LIMIT = 100000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_tvalid       = 1'b0;
    logic [31:0] s_tdata        = '0;
    logic [1:0]  s_tuser        = i2cram_pkg::OP_TICK;
    logic        m_tready       = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [7:0]  cfg_wr_data    = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [15:0] o_m_axis_tdata;
    wire         o_m_axis_tlast;

    bus_tick_scoreboard sb = new();

    // Sender burst state and the slave behavior for the current transfer.
    int burst_left = 0;
    int ack_slot   = -1;
    int fail_slot  = -1;
    int late_pct   = 0;
    int rx_mode    = 0;
    int settings_used = 1;
    int items_sent = 0;

    always #1 i_clk = ~i_clk;

    i2c_register_access_master_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    // Offer one tick request, honoring the burst and gap pattern of the sender.
    task automatic offer(i2cram_pkg::t_op op, logic [31:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0) begin
                @(negedge i_clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_tick(op, data);
        items_sent++;
    endtask

    // Build the next tick of a running transfer: mostly plain ticks, some ignored
    // commands, and an SDA sample that plays the slave's part.
    function automatic void build_busy_tick(output i2cram_pkg::t_op op,
                                            output logic [31:0] data);
        int unsigned pick;
        logic        sda;
        pick = $urandom_range(0, 19);
        data = $urandom;
        if (pick < 16) op = i2cram_pkg::OP_TICK;
        else if (pick < 18) op = i2cram_pkg::OP_NOP;
        else if (pick == 18) op = i2cram_pkg::OP_WRITE;
        else op = i2cram_pkg::OP_READ;
        sda = 1'($urandom_range(0, 1));
        case (sb.seq_phase)
            i2cram_pkg::PH_AKL: ack_slot++;
            i2cram_pkg::PH_AKH: sda = (fail_slot >= 0 && ack_slot >= fail_slot) ||
                                      ($urandom_range(0, 99) < late_pct);
            i2cram_pkg::PH_RXH: begin
                if (rx_mode == 1) sda = 1'b1;
                else if (rx_mode == 2) sda = 1'b0;
            end
            default: ;
        endcase
        data[31] = sda;
    endfunction

    // Issue a command on the idle bus and keep ticking until the bus is idle again.
    task automatic run_command(i2cram_pkg::t_op op, logic [6:0] dev, logic [7:0] reg_addr,
                               logic [7:0] wr_byte, logic [7:0] count,
                               int fail_at, int late, int rxm);
        i2cram_pkg::t_op tick_op;
        logic [31:0]     tick_data;
        fail_slot = fail_at;
        late_pct  = late;
        rx_mode   = rxm;
        ack_slot  = -1;
        offer(op, {1'($urandom_range(0, 1)), count, wr_byte, reg_addr, dev});
        while (sb.seq_phase != i2cram_pkg::PH_IDLE) begin
            build_busy_tick(tick_op, tick_data);
            offer(tick_op, tick_data);
        end
    endtask

    task automatic idle_ticks(int count);
        repeat (count)
            offer($urandom_range(0, 1) ? i2cram_pkg::OP_TICK : i2cram_pkg::OP_NOP, $urandom);
    endtask

    // Let everything drain, then write the ACK timeout on a quiet block.
    task automatic set_ack_timeout(logic [7:0] value);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.expected_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.ack_timeout = value;
        burst_left = 0;
        settings_used++;
    endtask

    // Check every result the receiver accepts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_levels(o_m_axis_tdata, o_m_axis_tlast);
    end

    // Receiver readiness: stretches of full rate, random stalls and a fixed
    // pattern, plus one long hold-off so the block backs up into its input.
    initial begin : result_sink
        int  mode;
        int  span;
        int  k;
        bit  held_long;
        held_long = 1'b0;
        forever begin
            if (!held_long && sb.ticks_checked >= 300) begin
                held_long = 1'b1;
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ((k % 5) < 3);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Main sequence: reset, directed transfers, then random transfers that each
    // run under the next timeout setting until the request budget is spent.
    initial begin : stimulus
        logic [7:0]      timeouts[7];
        int              p;
        int              pick;
        int              wait_cycles;
        i2cram_pkg::t_op op;
        logic [7:0]      count;
        timeouts[0] = 8'd0;
        timeouts[1] = 8'd3;
        timeouts[2] = 8'($urandom_range(4, 40));
        timeouts[3] = 8'd255;
        timeouts[4] = 8'd1;
        timeouts[5] = 8'd128;
        timeouts[6] = 8'($urandom_range(4, 254));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, field extremes, a read with a zero byte count and one of
        // several bytes with late ACKs, then slaves that never ACK at each byte
        // under a short timeout.
        offer(i2cram_pkg::OP_NOP, 32'hFFFF_FFFF);
        offer(i2cram_pkg::OP_TICK, 32'h0000_0000);
        run_command(i2cram_pkg::OP_WRITE, 7'h00, 8'h00, 8'h00, 8'd0, -1, 0, 0);
        run_command(i2cram_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'd255, -1, 0, 0);
        run_command(i2cram_pkg::OP_READ, 7'h68, 8'h75, 8'h00, 8'd0, -1, 0, 1);
        run_command(i2cram_pkg::OP_READ, 7'h2A, 8'h01, 8'hA5, 8'd3, -1, 30, 0);
        set_ack_timeout(8'd1);
        run_command(i2cram_pkg::OP_WRITE, 7'h11, 8'h22, 8'h33, 8'd1, 0, 0, 0);
        run_command(i2cram_pkg::OP_READ, 7'h44, 8'h55, 8'h66, 8'd2, 1, 0, 0);
        run_command(i2cram_pkg::OP_READ, 7'h0F, 8'hF0, 8'h0F, 8'd4, 2, 0, 0);
        idle_ticks(3);

        // Random transfers, each under the next timeout setting.
        p = 0;
        while (items_sent < ITEM_TARGET) begin
            set_ack_timeout(timeouts[p % 7]);
            idle_ticks($urandom_range(0, 3));
            op = $urandom_range(0, 1) ? i2cram_pkg::OP_WRITE : i2cram_pkg::OP_READ;
            pick = $urandom_range(0, 19);
            if (pick < 3) count = 8'd0;
            else if (pick < 17) count = 8'($urandom_range(1, 4));
            else count = 8'($urandom_range(5, 8));
            run_command(op, 7'($urandom), 8'($urandom), 8'($urandom), count,
                        (timeouts[p % 7] <= 8'd8 && $urandom_range(0, 3) == 0) ?
                            int'($urandom_range(0, 2)) : -1,
                        ($urandom_range(0, 3) == 0) ? int'($urandom_range(10, 60)) : 0,
                        ($urandom_range(0, 9) < 2) ? int'($urandom_range(1, 2)) : 0);
            p++;
        end

        // Drain the results still in flight, then allow for the pipeline depth.
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.expected_levels.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.expected_levels.size() != 0)
            sb.report($sformatf("%0d ticks never produced a result",
                                sb.expected_levels.size()));

        $display("Checked %0d bus ticks: %0d writes and %0d reads started, %0d bytes read.",
                 sb.ticks_checked, sb.writes_started, sb.reads_started, sb.bytes_read);
        $display("%0d transfers finished, %0d of them aborted on ACK timeout, over %0d settings.",
                 sb.transfers_done, sb.transfers_aborted, settings_used);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #40_000_000;
        $display("Run timed out with %0d ticks still pending.", sb.expected_levels.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== i2c_register_access_master_core.f =====
rtl/i2cram_pkg.sv
rtl/i2c_register_access_master.sv
tb/sv/i2c_register_access_master_core_tb.sv
